FILE: rtl/pspan_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspan_pkg
// Widths, constants and sequencer state type shared by the stereo spread
// panner files.
// ----------------------------------------------------------------------------
package pspan_pkg;

	localparam int SMP_W      = 16;
	localparam int CNT_W      = 5;
	localparam int CV_W       = 16;
	localparam int SUM_W      = 21;
	localparam int MUL_W      = 18;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int FRAC_W     = 16;
	localparam int POS_W      = 16;
	localparam int DIV_CNT_W  = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_KNOB = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_KNOB = 1'd1;

	localparam logic [CFG_DATA_W-1:0] SPREAD_KNOB_RST = 16'd16384;
	localparam logic [CFG_DATA_W-1:0] CENTER_KNOB_RST = 16'd0;

	localparam logic [FRAC_W-1:0] HALF_Q15 = 16'd16384;
	localparam logic [POS_W-1:0]  ONE_Q15  = 16'd32768;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_DIV  = 7'b0000010,
		ST_MULP = 7'b0000100,
		ST_POS  = 7'b0001000,
		ST_MULR = 7'b0010000,
		ST_MULL = 7'b0100000,
		ST_ACC  = 7'b1000000
	} state_t;

endpackage

FILE: rtl/pspan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspan_if
// Valid/ready channel interfaces: channel sample input and stereo sum output.
// ----------------------------------------------------------------------------
interface pspan_in_if;
	import pspan_pkg::*;

	logic             valid;
	logic             ready;
	logic [SMP_W-1:0] sample;
	logic [CNT_W-1:0] channel_count;
	logic [CV_W-1:0]  spread_cv;
	logic [CV_W-1:0]  center_cv;

	modport source (output valid, sample, channel_count, spread_cv, center_cv,
		input ready);
	modport sink (input valid, sample, channel_count, spread_cv, center_cv,
		output ready);
endinterface

interface pspan_out_if;
	import pspan_pkg::*;

	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] left_sum;
	logic [SUM_W-1:0] right_sum;

	modport source (output valid, left_sum, right_sum, input ready);
	modport sink (input valid, left_sum, right_sum, output ready);
endinterface

FILE: rtl/poly_to_stereo_spread_panner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_to_stereo_spread_panner_top
// Pans the channels of a polyphonic frame across the stereo field and sums
// them into left and right outputs.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one channel sample per transaction with the frame's channel
//   count and the spread and center control voltages. After the last channel
//   of a frame, out_ch carries one transaction with the left and right sums.
//   cfg_we/cfg_index/cfg_data write the spread knob (0) and center knob (1);
//   write only while the block is idle.
// Timing:
//   A single-channel frame skips the divider; otherwise each channel first
//   passes through the bit-serial divider that forms the channel's spread
//   fraction. The multiplier is shared by the spread term and both pan gains,
//   one product per cycle. The sums appear on out_ch in the cycle after the
//   last channel finishes.
// Reset and stall:
//   arst_n clears the sequencer, channel index, sums and output valid, and
//   loads the knob defaults. One finished result is held in the output
//   register; a frame that ends while it is still unread waits for out_ch.
// ----------------------------------------------------------------------------
module poly_to_stereo_spread_panner_top #(
	parameter int MAX_CHANNELS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	pspan_in_if.sink                            in_ch,
	pspan_out_if.source                         out_ch,
	input  logic                                cfg_we,
	input  logic [pspan_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pspan_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pspan_pkg::*;

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_CHANNELS);

	state_t                    state_q;
	logic [CFG_DATA_W-1:0]     spread_knob_q;
	logic [CFG_DATA_W-1:0]     center_knob_q;
	logic [IDX_W-1:0]          idx_q;
	logic signed [SUM_W-1:0]   left_acc_q;
	logic signed [SUM_W-1:0]   right_acc_q;
	logic signed [SMP_W-1:0]   sample_q;
	logic signed [MUL_W-1:0]   spread_q;
	logic signed [CV_W:0]      center_q;
	logic [CNT_W-1:0]          n_q;
	logic [CNT_W-1:0]          c_q;
	logic [DIV_CNT_W-1:0]      d_q;
	logic [CNT_W-1:0]          rem_q;
	logic [DIV_CNT_W-1:0]      div_cnt_q;
	logic [FRAC_W-1:0]         frac_q;
	logic [POS_W-1:0]          pos_q;
	logic                      out_valid_q;
	logic signed [SUM_W-1:0]   left_out_q;
	logic signed [SUM_W-1:0]   right_out_q;

	logic                      in_acc;
	logic [CNT_W-1:0]          n_in;
	logic [CNT_W-1:0]          c_in;
	logic [CNT_W-1:0]          r_in;
	logic                      q_bit;
	logic                      mul_en;
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [19:0]        pos_raw;
	logic signed [SMP_W:0]     contrib;
	logic signed [SUM_W-1:0]   left_next;
	logic                      last_ch;
	logic                      acc_stall;
	logic                      out_load;

	pspan_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_comb begin
		if (in_ch.channel_count == '0) begin
			n_in = CNT_W'(1);
		end else if (in_ch.channel_count > MAX_N) begin
			n_in = MAX_N;
		end else begin
			n_in = in_ch.channel_count;
		end
		if (CNT_W'(idx_q) > n_in - CNT_W'(1)) begin
			c_in = n_in - CNT_W'(1);
		end else begin
			c_in = CNT_W'(idx_q);
		end
	end

	// restoring divider step: one quotient bit of c * 2^15 / d per cycle
	assign r_in  = (div_cnt_q == '0) ? c_q : {rem_q[CNT_W-2:0], 1'b0};
	assign q_bit = (r_in >= {1'b0, d_q});

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_MULP: begin
				mul_a = $signed({2'b00, frac_q}) - $signed({2'b00, HALF_Q15});
				mul_b = spread_q;
			end
			ST_MULR: begin
				mul_a = MUL_W'(sample_q);
				mul_b = $signed({2'b00, pos_q});
			end
			ST_MULL: begin
				mul_a = MUL_W'(sample_q);
				mul_b = $signed({2'b00, ONE_Q15}) - $signed({2'b00, pos_q});
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign pos_raw   = prod[34:15] + 20'(center_q) + $signed({4'b0000, HALF_Q15});
	assign contrib   = prod[31:15];
	assign left_next = left_acc_q + SUM_W'(contrib);
	assign last_ch   = (CNT_W'(idx_q) + CNT_W'(1) >= n_q);
	assign acc_stall = last_ch && out_valid_q && !out_ch.ready;
	assign out_load  = (state_q == ST_ACC) && last_ch && !acc_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spread_knob_q <= SPREAD_KNOB_RST;
			center_knob_q <= CENTER_KNOB_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SPREAD_KNOB: spread_knob_q <= cfg_data;
				CFG_CENTER_KNOB: center_knob_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			left_acc_q  <= '0;
			right_acc_q <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						div_cnt_q <= '0;
						state_q   <= (n_in == CNT_W'(1)) ? ST_MULP : ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == '1) begin
						state_q <= ST_MULP;
					end
				end
				ST_MULP: state_q <= ST_POS;
				ST_POS:  state_q <= ST_MULR;
				ST_MULR: state_q <= ST_MULL;
				ST_MULL: begin
					right_acc_q <= right_acc_q + SUM_W'(contrib);
					state_q     <= ST_ACC;
				end
				ST_ACC: begin
					if (!acc_stall) begin
						state_q <= ST_IDLE;
						if (last_ch) begin
							idx_q       <= '0;
							left_acc_q  <= '0;
							right_acc_q <= '0;
							out_valid_q <= 1'b1;
						end else begin
							idx_q      <= idx_q + IDX_W'(1);
							left_acc_q <= left_next;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= in_ch.sample;
			spread_q <= MUL_W'($signed(in_ch.spread_cv)) + $signed({2'b00, spread_knob_q});
			center_q <= (CV_W+1)'($signed(in_ch.center_cv))
				+ (CV_W+1)'($signed(center_knob_q));
			n_q      <= n_in;
			c_q      <= c_in;
			d_q      <= DIV_CNT_W'(n_in - CNT_W'(1));
			if (n_in == CNT_W'(1)) begin
				frac_q <= HALF_Q15;
			end
		end
		if (state_q == ST_DIV) begin
			rem_q  <= q_bit ? (r_in - {1'b0, d_q}) : r_in;
			frac_q <= {frac_q[FRAC_W-2:0], q_bit};
		end
		if (state_q == ST_POS) begin
			if (pos_raw < 0) begin
				pos_q <= '0;
			end else if (pos_raw > $signed({4'b0000, ONE_Q15})) begin
				pos_q <= ONE_Q15;
			end else begin
				pos_q <= pos_raw[POS_W-1:0];
			end
		end
		if (out_load) begin
			left_out_q  <= left_next;
			right_out_q <= right_acc_q;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.left_sum  = left_out_q;
	assign out_ch.right_sum = right_out_q;

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_cnt_q != '0) |-> (rem_q < {1'b0, d_q}))
		else $error("divider remainder not below divisor");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULR) |-> (pos_q <= ONE_Q15))
		else $error("pan position out of range");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_ACC))
		else $error("result raised outside accumulate step");

	a_single_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && n_in == CNT_W'(1)) |=> (state_q == ST_MULP))
		else $error("single channel frame entered divider");

endmodule

FILE: rtl/pspan_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspan_mul
// Shared signed multiplier with a registered product, reused for the spread
// term and both pan gains.
// ----------------------------------------------------------------------------
module pspan_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [pspan_pkg::MUL_W-1:0]  a,
	input  logic signed [pspan_pkg::MUL_W-1:0]  b,
	output logic signed [pspan_pkg::PROD_W-1:0] prod
);
	import pspan_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule
